>>> rtl/core/sefr_pkg.sv
`default_nettype none

package sefr_pkg;

  // default payload store depth
  localparam int unsigned DEFAULT_BUFFER_DEPTH = 256;

  // configuration register indexes
  localparam logic CFG_START_BYTE = 1'b0;
  localparam logic CFG_END_BYTE   = 1'b1;

  // configuration reset values
  localparam logic [7:0] START_BYTE_RST = 8'h02;
  localparam logic [7:0] END_BYTE_RST   = 8'h03;

  typedef enum logic [1:0] {
    CMD_RECV  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_WAIT   = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    FS_IDLE = 3'd0,
    FS_LEN  = 3'd1,
    FS_DATA = 3'd2,
    FS_CHK  = 3'd3,
    FS_END  = 3'd4
  } fstate_e;

  typedef struct packed {
    status_e    status;
    logic [7:0] read_data;
    logic [7:0] payload_length;
    logic       frame_ready;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/stx_etx_frame_receiver_unit.sv
`default_nettype none

// Framed byte receiver: start byte, length, payload, additive checksum, end
// byte. Each input item carries a command in s_axis_tuser_i (receive the byte
// in tdata[7:0], read the stored payload at tdata[15:8], or reset the framer)
// and produces exactly one result item. The block takes one item per clock
// cycle while the output is not stalled; a result passes through the framer
// update and registered memory read, then the output register. Backpressure
// on the output stalls the input only once both stages are full. start_byte
// and end_byte are written through the cfg port; the user must write them
// only while the block is idle, which the block does not enforce. The payload
// memory needs no clearing pass after reset: reads are masked to the received
// length, and entries below it that were never written read as undefined data.
module stx_etx_frame_receiver_unit #(
  parameter int unsigned BUFFER_DEPTH = sefr_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [7:0]  cfg_wdata_i,
  // input items
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,  // rx_byte[7:0], read_index[15:8]
  input  wire logic [1:0]  s_axis_tuser_i,  // cmd[1:0]
  // result items
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [15:0] m_axis_tdata_o,  // read_data[7:0], payload_length[15:8]
  output      logic [2:0]  m_axis_tuser_o   // status[1:0], frame_ready[2]
);
  import sefr_pkg::*;

  logic       start_q;
  logic [7:0] start_byte_q;
  logic [7:0] end_byte_q;
  logic       in_acc;
  logic       s1_valid_q;
  logic       s1_adv;
  logic       out_valid_q;
  result_t    s1_res;
  result_t    out_q;
  cmd_e       cmd;

  assign cmd = cmd_e'(s_axis_tuser_i);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= START_BYTE_RST;
      end_byte_q   <= END_BYTE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_BYTE: start_byte_q <= cfg_wdata_i;
        CFG_END_BYTE:   end_byte_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stage one moves on whenever the output register is empty or being drained
  assign s1_adv          = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // framer state, payload memory and stage-one result
  sefr_framer #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (in_acc),
    .cmd_i        (cmd),
    .rx_byte_i    (s_axis_tdata_i[7:0]),
    .read_index_i (s_axis_tdata_i[15:8]),
    .start_byte_i (start_byte_q),
    .end_byte_i   (end_byte_q),
    .res_o        (s1_res)
  );

  // stage one valid tracks what the framer holds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      start_q     <= 1'b0;
    end else begin
      start_q <= 1'b1;
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_q <= s1_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.payload_length, out_q.read_data};
  assign m_axis_tuser_o  = {out_q.frame_ready, out_q.status};

  // an accepted frame always leaves the ready flag set
  a_accept_sets_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status == ST_ACCEPT)) |-> out_q.frame_ready)
    else $error("accepted frame without ready flag");

  // a rejected frame never leaves the ready flag set
  a_reject_clears_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status == ST_REJECT)) |-> !out_q.frame_ready)
    else $error("rejected frame with ready flag");

  // input stalls only while both stages hold items
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_q && !s_axis_tready_o) |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with a free stage");

endmodule

`default_nettype wire

>>> rtl/core/sefr_framer.sv
`default_nettype none

module sefr_framer #(
  parameter int unsigned BUFFER_DEPTH = sefr_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             acc_i,
  input  wire sefr_pkg::cmd_e   cmd_i,
  input  wire logic [7:0]       rx_byte_i,
  input  wire logic [7:0]       read_index_i,
  input  wire logic [7:0]       start_byte_i,
  input  wire logic [7:0]       end_byte_i,
  output sefr_pkg::result_t     res_o
);
  import sefr_pkg::*;

  localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [8:0] DepthW = 9'(BUFFER_DEPTH);

  fstate_e    state_q, state_d;
  logic [7:0] exp_len_q, exp_len_d;
  logic [7:0] count_q, count_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] chk_q, chk_d;
  logic       rdy_q, rdy_d;
  logic [7:0] count_inc;
  logic       len_ok;
  logic       frame_good;
  logic       wr_en;
  logic       rd_hit_d, rd_hit_q;
  status_e    status_d, status_q;
  logic [7:0] mem_rd_q;

  logic [7:0] mem [BUFFER_DEPTH];

  assign count_inc  = count_q + 8'd1;
  assign len_ok     = (rx_byte_i != 8'd0) && ({1'b0, rx_byte_i} <= DepthW);
  assign frame_good = (rx_byte_i == end_byte_i) && (sum_q == chk_q);

  // next state
  always_comb begin
    state_d = state_q;
    if (acc_i) begin
      unique case (cmd_i)
        CMD_RECV: begin
          unique case (state_q)
            FS_IDLE: if (rx_byte_i == start_byte_i) state_d = FS_LEN;
            FS_LEN:  state_d = len_ok ? FS_DATA : FS_IDLE;
            FS_DATA: if (count_inc >= exp_len_q) state_d = FS_CHK;
            FS_CHK:  state_d = FS_END;
            default: state_d = FS_IDLE;
          endcase
        end
        CMD_CLEAR: state_d = FS_IDLE;
        default: ;
      endcase
    end
  end

  // datapath updates and result
  always_comb begin
    exp_len_d = exp_len_q;
    count_d   = count_q;
    sum_d     = sum_q;
    chk_d     = chk_q;
    rdy_d     = rdy_q;
    status_d  = ST_WAIT;
    wr_en     = 1'b0;
    rd_hit_d  = 1'b0;
    if (acc_i) begin
      unique case (cmd_i)
        CMD_RECV: begin
          unique case (state_q)
            FS_IDLE: begin
              if (rx_byte_i == start_byte_i) begin
                count_d = 8'd0;
                sum_d   = 8'd0;
                rdy_d   = 1'b0;
              end
            end
            FS_LEN: if (len_ok) exp_len_d = rx_byte_i;
            FS_DATA: begin
              wr_en   = {1'b0, count_q} < DepthW;
              sum_d   = sum_q + rx_byte_i;
              count_d = count_inc;
            end
            FS_CHK: chk_d = rx_byte_i;
            FS_END: begin
              if (frame_good) begin
                rdy_d    = 1'b1;
                status_d = ST_ACCEPT;
              end else begin
                status_d = ST_REJECT;
              end
            end
            default: ;
          endcase
        end
        CMD_READ: begin
          rd_hit_d = (read_index_i < exp_len_q) && ({1'b0, read_index_i} < DepthW);
        end
        CMD_CLEAR: begin
          count_d = 8'd0;
          sum_d   = 8'd0;
          rdy_d   = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FS_IDLE;
      exp_len_q <= 8'd0;
      count_q   <= 8'd0;
      sum_q     <= 8'd0;
      chk_q     <= 8'd0;
      rdy_q     <= 1'b0;
      rd_hit_q  <= 1'b0;
      status_q  <= ST_WAIT;
    end else begin
      state_q   <= state_d;
      exp_len_q <= exp_len_d;
      count_q   <= count_d;
      sum_q     <= sum_d;
      chk_q     <= chk_d;
      rdy_q     <= rdy_d;
      if (acc_i) begin
        rd_hit_q <= rd_hit_d;
        status_q <= status_d;
      end
    end
  end

  // payload store, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[AW-1:0]] <= rx_byte_i;
    end
    if (acc_i && rd_hit_d) begin
      mem_rd_q <= mem[read_index_i[AW-1:0]];
    end
  end

  assign res_o.status         = status_q;
  assign res_o.read_data      = rd_hit_q ? mem_rd_q : 8'd0;
  assign res_o.payload_length = exp_len_q;
  assign res_o.frame_ready    = rdy_q;

  a_data_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FS_DATA) |-> (exp_len_q != 8'd0))
    else $error("payload phase with zero length");

  a_data_count_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FS_DATA) |-> (count_q < exp_len_q))
    else $error("payload count reached length without leaving payload phase");

  a_read_beyond_len_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && (cmd_i == CMD_READ) && (read_index_i >= exp_len_q)) |=> !rd_hit_q)
    else $error("read beyond length not masked");

endmodule

`default_nettype wire
